[rtl/clf_pkg.sv]
package clf_pkg;

  // Block sizing
  localparam int LINE_CAPACITY = 40;
  localparam int QUEUE_LINES   = 8;
  localparam int LINK_COUNT    = 2;

  localparam int LINE_MAX = LINE_CAPACITY - 1;
  localparam int LEN_W    = $clog2(LINE_CAPACITY);
  localparam int LINK_W   = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
  localparam int SLOT_W   = (QUEUE_LINES > 1) ? $clog2(QUEUE_LINES) : 1;
  localparam int FILL_W   = $clog2(QUEUE_LINES + 1);

  localparam int LK_DEPTH = LINK_COUNT * LINE_MAX;
  localparam int LK_AW    = (LK_DEPTH > 1) ? $clog2(LK_DEPTH) : 1;
  localparam int QS_DEPTH = QUEUE_LINES * LINE_MAX;
  localparam int QS_AW    = (QS_DEPTH > 1) ? $clog2(QS_DEPTH) : 1;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;
  localparam int CMDQ_CW    = 3;

  localparam int CNT_W = 32;

  // Operation codes on the input channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_HT      = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  // Classified command
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_EOL   = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_TAKE  = 2'd3
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t         code;
    logic [LINK_W-1:0] link;
    logic [7:0]        data;
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PULSE = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PULSE = 2'd1,
    ST_COPY  = 2'd2,
    ST_EMIT  = 2'd3
  } back_state_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_x(input logic [7:0] c);
    return (c == CH_UPPER_X) || (c == CH_LOWER_X);
  endfunction

endpackage

[rtl/clf_front.sv]
module clf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic              in_source,
  input  logic [7:0]        in_rx_byte,
  output logic              cmd_valid,
  output clf_pkg::cmd_t     cmd,
  input  logic              cmd_pop
);

  clf_pkg::cmd_t                 q_r [clf_pkg::CMDQ_DEPTH];
  logic [clf_pkg::CMDQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [clf_pkg::CMDQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [clf_pkg::CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  clf_pkg::cmd_t                 cls;
  logic                          bad_link;
  logic                          push;

  // Classify the incoming item
  assign bad_link = (in_operation == clf_pkg::OP_BYTE) &&
                    (int'(in_source) >= clf_pkg::LINK_COUNT);

  always_comb begin
    cls.link = clf_pkg::LINK_W'(in_source);
    cls.data = in_rx_byte;
    if (in_operation == clf_pkg::OP_TAKE) begin
      cls.code = clf_pkg::CMD_TAKE;
    end else if ((in_rx_byte == clf_pkg::CH_LF) || (in_rx_byte == clf_pkg::CH_CR)) begin
      cls.code = clf_pkg::CMD_EOL;
    end else if (in_rx_byte == clf_pkg::CH_NUL) begin
      cls.code = clf_pkg::CMD_COUNT;
    end else begin
      cls.code = clf_pkg::CMD_BYTE;
    end
  end

  // Command queue
  assign in_ready  = (cnt_r != clf_pkg::CMDQ_CW'(clf_pkg::CMDQ_DEPTH));
  assign push      = in_valid && in_ready && !bad_link;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[rtl/clf_back.sv]
module clf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              emergency_enable,
  input  logic              cmd_valid,
  input  clf_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [7:0]        out_line_char,
  output logic              out_last,
  output logic [31:0]       out_bytes_received,
  output logic [31:0]       out_lines_dropped
);

  localparam int LEN_W  = clf_pkg::LEN_W;
  localparam int SLOT_W = clf_pkg::SLOT_W;
  localparam int FILL_W = clf_pkg::FILL_W;
  localparam int CNT_W  = clf_pkg::CNT_W;

  clf_pkg::back_state_t state_r, state_nxt;

  // Per-link line trackers
  logic [LEN_W-1:0] lk_len_r   [clf_pkg::LINK_COUNT];
  logic [LEN_W-1:0] lk_len_nxt [clf_pkg::LINK_COUNT];
  logic             lk_nb_r    [clf_pkg::LINK_COUNT];
  logic             lk_nb_nxt  [clf_pkg::LINK_COUNT];
  logic [LEN_W-1:0] lk_first_r   [clf_pkg::LINK_COUNT];
  logic [LEN_W-1:0] lk_first_nxt [clf_pkg::LINK_COUNT];
  logic [LEN_W-1:0] lk_end_r     [clf_pkg::LINK_COUNT];
  logic [LEN_W-1:0] lk_end_nxt   [clf_pkg::LINK_COUNT];
  logic             lk_x_r       [clf_pkg::LINK_COUNT];
  logic             lk_x_nxt     [clf_pkg::LINK_COUNT];

  // Line queue bookkeeping
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0]  q_len_r   [clf_pkg::QUEUE_LINES];
  logic [LEN_W-1:0]  q_len_nxt [clf_pkg::QUEUE_LINES];

  logic [CNT_W-1:0] rcv_r, rcv_nxt;
  logic [CNT_W-1:0] drop_r, drop_nxt;

  // Copy sequencer
  logic [clf_pkg::LINK_W-1:0] cp_link_r, cp_link_nxt;
  logic [LEN_W-1:0]           cp_rd_pos_r, cp_rd_pos_nxt;
  logic [LEN_W-1:0]           cp_end_r, cp_end_nxt;
  logic [clf_pkg::QS_AW-1:0]  cp_wr_addr_r, cp_wr_addr_nxt;
  logic                       cp_v_r, cp_v_nxt;
  logic                       cp_go_r, cp_go_nxt;

  // Emit sequencer
  logic [clf_pkg::QS_AW-1:0]  em_base_r, em_base_nxt;
  logic [LEN_W-1:0]           em_idx_r, em_idx_nxt;
  logic [LEN_W-1:0]           em_len_r, em_len_nxt;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  clf_pkg::kind_t   out_kind_r, out_kind_nxt;
  logic             out_last_r, out_last_nxt;
  logic [CNT_W-1:0] out_bytes_r, out_bytes_nxt;
  logic [CNT_W-1:0] out_drops_r, out_drops_nxt;
  logic             out_ld;
  logic             out_free;

  // Memories
  logic [7:0] lk_mem [clf_pkg::LK_DEPTH];
  logic [7:0] q_mem  [clf_pkg::QS_DEPTH];
  logic [7:0] lk_q;
  logic [7:0] q_q;
  logic                      lk_we, lk_re, q_we, q_re;
  logic [clf_pkg::LK_AW-1:0] lk_wa, lk_ra;
  logic [clf_pkg::QS_AW-1:0] q_wa, q_ra;

  // Lookups for the current command and the queue ends
  logic [LEN_W-1:0]          c_len, c_first, c_end;
  logic                      c_nb, c_x;
  logic [SLOT_W-1:0]         tail_slot;
  logic [clf_pkg::QS_AW-1:0] tail_base, head_base;
  logic [LEN_W-1:0]          head_len;
  logic                      q_full;
  logic                      em_last;
  int                        tail_sum;

  assign c_len   = lk_len_r[cmd.link];
  assign c_first = lk_first_r[cmd.link];
  assign c_end   = lk_end_r[cmd.link];
  assign c_nb    = lk_nb_r[cmd.link];
  assign c_x     = lk_x_r[cmd.link];

  assign tail_sum  = int'(head_r) + int'(fill_r);
  assign tail_slot = (tail_sum >= clf_pkg::QUEUE_LINES) ?
                     SLOT_W'(tail_sum - clf_pkg::QUEUE_LINES) : SLOT_W'(tail_sum);
  assign tail_base = clf_pkg::QS_AW'(int'(tail_slot) * clf_pkg::LINE_MAX);
  assign head_base = clf_pkg::QS_AW'(int'(head_r) * clf_pkg::LINE_MAX);
  assign head_len  = q_len_r[head_r];
  assign q_full    = (fill_r == FILL_W'(clf_pkg::QUEUE_LINES));
  assign em_last   = (LEN_W'(em_idx_r + 1'b1) == em_len_r);

  assign out_free = !out_valid_r || out_ready;

  // Sequencer: next state, trackers, memory controls, output load
  always_comb begin
    state_nxt      = state_r;
    lk_len_nxt     = lk_len_r;
    lk_nb_nxt      = lk_nb_r;
    lk_first_nxt   = lk_first_r;
    lk_end_nxt     = lk_end_r;
    lk_x_nxt       = lk_x_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    q_len_nxt      = q_len_r;
    rcv_nxt        = rcv_r;
    drop_nxt       = drop_r;
    cp_link_nxt    = cp_link_r;
    cp_rd_pos_nxt  = cp_rd_pos_r;
    cp_end_nxt     = cp_end_r;
    cp_wr_addr_nxt = cp_wr_addr_r;
    cp_v_nxt       = 1'b0;
    cp_go_nxt      = cp_go_r;
    em_base_nxt    = em_base_r;
    em_idx_nxt     = em_idx_r;
    em_len_nxt     = em_len_r;
    out_ld         = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_bytes_nxt  = out_bytes_r;
    out_drops_nxt  = out_drops_r;
    cmd_pop        = 1'b0;
    lk_we          = 1'b0;
    lk_wa          = clf_pkg::LK_AW'(int'(cmd.link) * clf_pkg::LINE_MAX + int'(c_len));
    lk_re          = 1'b0;
    lk_ra          = clf_pkg::LK_AW'(int'(cp_link_r) * clf_pkg::LINE_MAX +
                                     int'(cp_rd_pos_r));
    q_we           = 1'b0;
    q_wa           = cp_wr_addr_r;
    q_re           = 1'b0;
    q_ra           = clf_pkg::QS_AW'(em_base_r + clf_pkg::QS_AW'(em_idx_r));

    case (state_r)
      clf_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.code)
            // Store a byte and track the trimmed extent
            clf_pkg::CMD_BYTE: begin
              cmd_pop = 1'b1;
              rcv_nxt = rcv_r + 1'b1;
              if (int'(c_len) < clf_pkg::LINE_MAX) begin
                lk_we = 1'b1;
                lk_len_nxt[cmd.link] = c_len + 1'b1;
                if (!clf_pkg::is_blank(cmd.data)) begin
                  if (!c_nb) begin
                    lk_nb_nxt[cmd.link]    = 1'b1;
                    lk_first_nxt[cmd.link] = c_len;
                    lk_x_nxt[cmd.link]     = clf_pkg::is_x(cmd.data);
                  end
                  lk_end_nxt[cmd.link] = c_len + 1'b1;
                end
              end
            end
            // Zero byte: counted only
            clf_pkg::CMD_COUNT: begin
              cmd_pop = 1'b1;
              rcv_nxt = rcv_r + 1'b1;
            end
            // Line end: close a non-empty line
            clf_pkg::CMD_EOL: begin
              cmd_pop = 1'b1;
              rcv_nxt = rcv_r + 1'b1;
              if (c_len != '0) begin
                lk_len_nxt[cmd.link] = '0;
                lk_nb_nxt[cmd.link]  = 1'b0;
                if (c_nb) begin
                  cp_go_nxt = !q_full;
                  if (q_full) begin
                    drop_nxt = drop_r + 1'b1;
                  end else begin
                    q_len_nxt[tail_slot] = c_end - c_first;
                    fill_nxt       = fill_r + 1'b1;
                    cp_link_nxt    = cmd.link;
                    cp_rd_pos_nxt  = c_first;
                    cp_end_nxt     = c_end;
                    cp_wr_addr_nxt = tail_base;
                  end
                  if (c_x && emergency_enable) begin
                    state_nxt = clf_pkg::ST_PULSE;
                  end else if (!q_full) begin
                    state_nxt = clf_pkg::ST_COPY;
                  end
                end
              end
            end
            // Take request: empty answer or first character
            clf_pkg::CMD_TAKE: begin
              if (out_free) begin
                cmd_pop       = 1'b1;
                out_ld        = 1'b1;
                out_bytes_nxt = rcv_r;
                out_drops_nxt = drop_r;
                if (fill_r != '0) begin
                  head_nxt = (head_r == SLOT_W'(clf_pkg::QUEUE_LINES - 1)) ?
                             '0 : head_r + 1'b1;
                  fill_nxt = fill_r - 1'b1;
                end
                if ((fill_r == '0) || (head_len == '0)) begin
                  out_kind_nxt = clf_pkg::KIND_EMPTY;
                  out_last_nxt = 1'b1;
                end else begin
                  q_re         = 1'b1;
                  q_ra         = head_base;
                  out_kind_nxt = clf_pkg::KIND_CHAR;
                  out_last_nxt = (head_len == LEN_W'(1));
                  em_base_nxt  = head_base;
                  em_idx_nxt   = LEN_W'(1);
                  em_len_nxt   = head_len;
                  if (head_len != LEN_W'(1)) begin
                    state_nxt = clf_pkg::ST_EMIT;
                  end
                end
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end

      // Emergency pulse, counters already updated for this item
      clf_pkg::ST_PULSE: begin
        if (out_free) begin
          out_ld        = 1'b1;
          out_kind_nxt  = clf_pkg::KIND_PULSE;
          out_last_nxt  = 1'b1;
          out_bytes_nxt = rcv_r;
          out_drops_nxt = drop_r;
          state_nxt     = cp_go_r ? clf_pkg::ST_COPY : clf_pkg::ST_IDLE;
        end
      end

      // Copy trimmed line into its queue slot, one byte a cycle
      clf_pkg::ST_COPY: begin
        if (cp_rd_pos_r != cp_end_r) begin
          lk_re         = 1'b1;
          cp_rd_pos_nxt = cp_rd_pos_r + 1'b1;
          cp_v_nxt      = 1'b1;
        end
        if (cp_v_r) begin
          q_we           = 1'b1;
          cp_wr_addr_nxt = cp_wr_addr_r + 1'b1;
          if (cp_rd_pos_r == cp_end_r) begin
            state_nxt = clf_pkg::ST_IDLE;
          end
        end
      end

      // Stream remaining characters of the taken line
      clf_pkg::ST_EMIT: begin
        if (out_free) begin
          out_ld       = 1'b1;
          q_re         = 1'b1;
          out_kind_nxt = clf_pkg::KIND_CHAR;
          out_last_nxt = em_last;
          em_idx_nxt   = em_idx_r + 1'b1;
          if (em_last) begin
            state_nxt = clf_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = clf_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt = out_ld || (out_valid_r && !out_ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clf_pkg::ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      rcv_r       <= '0;
      drop_r      <= '0;
      cp_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < clf_pkg::LINK_COUNT; i++) begin
        lk_len_r[i] <= '0;
        lk_nb_r[i]  <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      rcv_r       <= rcv_nxt;
      drop_r      <= drop_nxt;
      cp_v_r      <= cp_v_nxt;
      out_valid_r <= out_valid_nxt;
      lk_len_r    <= lk_len_nxt;
      lk_nb_r     <= lk_nb_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lk_first_r   <= lk_first_nxt;
    lk_end_r     <= lk_end_nxt;
    lk_x_r       <= lk_x_nxt;
    q_len_r      <= q_len_nxt;
    cp_link_r    <= cp_link_nxt;
    cp_rd_pos_r  <= cp_rd_pos_nxt;
    cp_end_r     <= cp_end_nxt;
    cp_wr_addr_r <= cp_wr_addr_nxt;
    cp_go_r      <= cp_go_nxt;
    em_base_r    <= em_base_nxt;
    em_idx_r     <= em_idx_nxt;
    em_len_r     <= em_len_nxt;
    out_kind_r   <= out_kind_nxt;
    out_last_r   <= out_last_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_drops_r  <= out_drops_nxt;
  end

  // Link line store
  always_ff @(posedge clk) begin
    if (lk_we) begin
      lk_mem[lk_wa] <= cmd.data;
    end
    if (lk_re) begin
      lk_q <= lk_mem[lk_ra];
    end
  end

  // Queued line store; read data feeds the result directly
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= lk_q;
    end
    if (q_re) begin
      q_q <= q_mem[q_ra];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_line_char      = (out_kind_r == clf_pkg::KIND_CHAR) ? q_q : clf_pkg::CH_NUL;
  assign out_last           = out_last_r;
  assign out_bytes_received = out_bytes_r;
  assign out_lines_dropped  = out_drops_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(clf_pkg::QUEUE_LINES))
    else $error("queue fill beyond capacity");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (drop_r != $past(drop_r))) |->
      ($past(fill_r) == FILL_W'(clf_pkg::QUEUE_LINES)))
    else $error("line dropped while queue had room");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clf_pkg::ST_COPY) |-> (cp_rd_pos_r <= cp_end_r))
    else $error("copy read ran past line end");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule

[rtl/command_line_framer_queue.sv]
// Items pass the command queue; bytes are then stored at one per cycle while the back end is
// idle. A closed line goes to an emergency pulse (if enabled and its first non-blank byte is X),
// then, if the queue has room, to a copy of the trimmed line. A take loads its first result,
// then one character per cycle while out_ready holds, set by the single queued-line read port.
// Reset (rst_n low, synchronous) clears counters, queue pointers, link lengths and the
// enable; line memories are not cleared and need no clearing pass.
module command_line_framer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic        in_source,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_line_char,
  output logic        out_last,
  output logic [31:0] out_bytes_received,
  output logic [31:0] out_lines_dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_emergency_enable
);

  logic          emergency_enable_r, emergency_enable_nxt;
  logic          cmd_valid;
  logic          cmd_pop;
  clf_pkg::cmd_t cmd;

  // Configuration register
  assign cfg_ready            = 1'b1;
  assign emergency_enable_nxt = (cfg_valid && cfg_ready) ? cfg_emergency_enable :
                                emergency_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emergency_enable_r <= 1'b0;
    end else begin
      emergency_enable_r <= emergency_enable_nxt;
    end
  end

  // Front: classify and queue items
  clf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_source    (in_source),
    .in_rx_byte   (in_rx_byte),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: line buffers, line queue and result generation
  clf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .emergency_enable   (emergency_enable_r),
    .cmd_valid          (cmd_valid),
    .cmd                (cmd),
    .cmd_pop            (cmd_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_line_char      (out_line_char),
    .out_last           (out_last),
    .out_bytes_received (out_bytes_received),
    .out_lines_dropped  (out_lines_dropped)
  );

endmodule
